// File: src/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg: shared types and constants of the temperature reading qualifier
// Holds field widths, register indexes and the per-zone calibration table.
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam int ZONES      = 7;
    localparam int ZONE_W     = 3;
    localparam int TEMP_W     = 12;
    localparam int RUN_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int GAIN_W     = 13;
    localparam int OFFS_W     = 8;
    localparam int FRAC_W     = 12;

    typedef logic [ZONE_W-1:0]        zone_t;
    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [RUN_W-1:0]         run_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic signed [OFFS_W-1:0] offs_t;

    // register map
    localparam cfg_idx_t REG_LOW_LIMIT  = 2'd0;
    localparam cfg_idx_t REG_HIGH_LIMIT = 2'd1;
    localparam cfg_idx_t REG_ERR_LIMIT  = 2'd2;
    localparam cfg_idx_t REG_FALLBACK   = 2'd3;

    localparam temp_t LOW_LIMIT_RST  = 12'sd80;
    localparam temp_t HIGH_LIMIT_RST = 12'sd1600;
    localparam run_t  ERR_LIMIT_RST  = 8'd50;
    localparam temp_t FALLBACK_RST   = 12'sd160;

    localparam run_t  RUN_MAX  = '1;
    localparam temp_t TEMP_MAX = 12'sd2047;
    localparam temp_t TEMP_MIN = -12'sd2048;

    // gain in units of 2^-12, zone 7 has no correction
    function automatic gain_t cal_gain(input zone_t zone);
        gain_t g;
        case (zone)
            3'd0:    g = 13'd4055;
            3'd1:    g = 13'd4076;
            3'd2:    g = 13'd4383;
            3'd3:    g = 13'd4014;
            3'd4:    g = 13'd4035;
            3'd5:    g = 13'd3994;
            3'd6:    g = 13'd4076;
            default: g = 13'd4096;
        endcase
        return g;
    endfunction

    // offset in sixteenths of a degree
    function automatic offs_t cal_offset(input zone_t zone);
        offs_t o;
        case (zone)
            3'd0:    o = 8'sd99;
            3'd1:    o = 8'sd35;
            3'd2:    o = -8'sd29;
            3'd3:    o = 8'sd104;
            3'd4:    o = 8'sd61;
            3'd5:    o = 8'sd29;
            3'd6:    o = 8'sd56;
            default: o = 8'sd0;
        endcase
        return o;
    endfunction

endpackage

// File: src/trq_ifs.sv
// ----------------------------------------------------------------------------
// trq channels: sample, result and configuration interfaces
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface trq_sample_if;
    logic            valid;
    logic            ready;
    trq_pkg::zone_t  zone_index;
    trq_pkg::temp_t  raw_temperature;

    modport source (output valid, output zone_index, output raw_temperature, input ready);
    modport sink   (input valid, input zone_index, input raw_temperature, output ready);
endinterface

interface trq_result_if;
    logic            valid;
    logic            ready;
    trq_pkg::zone_t  out_zone;
    trq_pkg::temp_t  zone_temperature_out;
    logic            sample_ok;
    logic            fallback_active;
    trq_pkg::run_t   error_run;
    trq_pkg::run_t   worst_error_run;

    modport source (output valid, output out_zone, output zone_temperature_out,
                    output sample_ok, output fallback_active, output error_run,
                    output worst_error_run, input ready);
    modport sink   (input valid, input out_zone, input zone_temperature_out,
                    input sample_ok, input fallback_active, input error_run,
                    input worst_error_run, output ready);
endinterface

interface trq_cfg_if;
    logic                valid;
    logic                ready;
    trq_pkg::cfg_idx_t   index;
    trq_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/temperature_reading_qualifier.sv
// ----------------------------------------------------------------------------
// temperature_reading_qualifier: per-zone plausibility check and calibration
// Qualifies one sample per word, tracks bad-sample runs, reports temperature.
// ----------------------------------------------------------------------------
// Usage:
//   sample : sink channel, one word = zone index and raw reading (1/16 degC).
//   result : source channel, one word per sample word, in the same order.
//   cfg    : write channel, index selects low limit, high limit, error limit
//            or fallback temperature; always ready. Write only while idle.
// Path: an accepted sample word is loaded into the input register, then into
//   the result register once that is free, and is offered on result from there.
// Throughput: one word per cycle while result is not held off. The per-zone
//   state is read, updated and written back in the same cycle the result
//   register loads, so the next word of the same zone already sees it.
// Reset: run counters, worst runs and zone temperatures clear to zero; the
//   registers take their default values; both pipeline stages empty.
// Stall: when result is held off, the result register keeps its word and the
//   input register holds one more; sample ready drops only once both are full.
// Zones beyond the last one leave the state untouched and return zeros.
// ----------------------------------------------------------------------------
module temperature_reading_qualifier (
    input  logic               clk,
    input  logic               rst_n,
    trq_sample_if.sink         sample,
    trq_result_if.source       result,
    trq_cfg_if.sink            cfg
);

    // configuration registers
    trq_pkg::temp_t low_limit_reg;
    trq_pkg::temp_t high_limit_reg;
    trq_pkg::run_t  err_limit_reg;
    trq_pkg::temp_t fallback_reg;

    // per-zone state
    trq_pkg::run_t  bad_run_reg  [trq_pkg::ZONES];
    trq_pkg::run_t  worst_run_reg[trq_pkg::ZONES];
    trq_pkg::temp_t zone_temp_reg[trq_pkg::ZONES];

    // input register
    logic           s1_valid_reg;
    trq_pkg::zone_t s1_zone_reg;
    trq_pkg::temp_t s1_raw_reg;

    // result register
    logic           out_valid_reg;
    trq_pkg::zone_t out_zone_reg;
    trq_pkg::temp_t out_temp_reg;
    logic           out_ok_reg;
    logic           out_forced_reg;
    trq_pkg::run_t  out_run_reg;
    trq_pkg::run_t  out_worst_reg;

    logic out_free;
    logic s1_fire;
    logic in_fire;
    logic zone_in_range;
    logic upd;

    trq_pkg::run_t  run_old;
    trq_pkg::run_t  worst_old;
    trq_pkg::temp_t temp_old;

    logic                         ok;
    logic                         forced;
    trq_pkg::run_t                run_next;
    trq_pkg::run_t                worst_next;
    trq_pkg::temp_t               temp_next;

    logic signed [trq_pkg::GAIN_W:0]   gain_s;
    logic signed [25:0]                prod;
    logic signed [25:0]                prod_rnd;
    logic signed [13:0]                cal_q;
    logic signed [14:0]                cal_sum;
    trq_pkg::temp_t                    cal_temp;

    // handshake: result register frees when empty or taken this cycle
    assign out_free     = !out_valid_reg || result.ready;
    assign s1_fire      = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;
    assign in_fire      = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign zone_in_range = (32'(s1_zone_reg) < trq_pkg::ZONES);
    assign upd           = s1_fire && zone_in_range;

    // read the zone's state; out-of-range zones never reach the write path
    always_comb
    begin
        if (zone_in_range)
        begin
            run_old   = bad_run_reg[s1_zone_reg];
            worst_old = worst_run_reg[s1_zone_reg];
            temp_old  = zone_temp_reg[s1_zone_reg];
        end
        else
        begin
            run_old   = '0;
            worst_old = '0;
            temp_old  = '0;
        end
    end

    // calibration: round(gain * raw / 4096) half up, add offset, clamp
    always_comb
    begin
        gain_s   = $signed({1'b0, trq_pkg::cal_gain(s1_zone_reg)});
        prod     = gain_s * s1_raw_reg;
        prod_rnd = prod + 26'sd2048;
        cal_q    = prod_rnd[25:trq_pkg::FRAC_W];
        cal_sum  = {cal_q[13], cal_q} + 15'(trq_pkg::cal_offset(s1_zone_reg));
        if (cal_sum > 15'(trq_pkg::TEMP_MAX))
            cal_temp = trq_pkg::TEMP_MAX;
        else if (cal_sum < 15'(trq_pkg::TEMP_MIN))
            cal_temp = trq_pkg::TEMP_MIN;
        else
            cal_temp = cal_sum[trq_pkg::TEMP_W-1:0];
    end

    // qualify and update the zone's run counters
    always_comb
    begin
        ok = (s1_raw_reg >= low_limit_reg) && (s1_raw_reg <= high_limit_reg);
        if (ok)
            run_next = '0;
        else if (run_old != trq_pkg::RUN_MAX)
            run_next = run_old + 8'd1;
        else
            run_next = run_old;
        worst_next = (worst_old < run_next) ? run_next : worst_old;
        forced     = !ok && (run_next > err_limit_reg);
        if (ok)
            temp_next = cal_temp;
        else if (forced)
            temp_next = fallback_reg;
        else
            temp_next = temp_old;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= trq_pkg::LOW_LIMIT_RST;
            high_limit_reg <= trq_pkg::HIGH_LIMIT_RST;
            err_limit_reg  <= trq_pkg::ERR_LIMIT_RST;
            fallback_reg   <= trq_pkg::FALLBACK_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                trq_pkg::REG_LOW_LIMIT:  low_limit_reg  <= cfg.data;
                trq_pkg::REG_HIGH_LIMIT: high_limit_reg <= cfg.data;
                trq_pkg::REG_ERR_LIMIT:  err_limit_reg  <= cfg.data[trq_pkg::RUN_W-1:0];
                trq_pkg::REG_FALLBACK:   fallback_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // per-zone state: write back when an in-range word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < trq_pkg::ZONES; i++)
            begin
                bad_run_reg[i]   <= '0;
                worst_run_reg[i] <= '0;
                zone_temp_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            bad_run_reg[s1_zone_reg]   <= run_next;
            worst_run_reg[s1_zone_reg] <= worst_next;
            zone_temp_reg[s1_zone_reg] <= temp_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sample.ready)
            s1_valid_reg <= sample.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_zone_reg <= sample.zone_index;
            s1_raw_reg  <= sample.raw_temperature;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    // result register payload; out-of-range zones report zeros
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_zone_reg <= s1_zone_reg;
            if (zone_in_range)
            begin
                out_temp_reg   <= temp_next;
                out_ok_reg     <= ok;
                out_forced_reg <= forced;
                out_run_reg    <= run_next;
                out_worst_reg  <= worst_next;
            end
            else
            begin
                out_temp_reg   <= '0;
                out_ok_reg     <= 1'b0;
                out_forced_reg <= 1'b0;
                out_run_reg    <= '0;
                out_worst_reg  <= '0;
            end
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.out_zone             = out_zone_reg;
    assign result.zone_temperature_out = out_temp_reg;
    assign result.sample_ok            = out_ok_reg;
    assign result.fallback_active      = out_forced_reg;
    assign result.error_run            = out_run_reg;
    assign result.worst_error_run      = out_worst_reg;

endmodule

// File: src/trq_checker.sv
// ----------------------------------------------------------------------------
// trq_checker: port-level checks of the temperature reading qualifier
// Watches the result channel and flags inconsistent or unstable words.
// ----------------------------------------------------------------------------
module trq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            res_valid,
    input logic            res_ready,
    input trq_pkg::zone_t  res_zone,
    input trq_pkg::temp_t  res_temp,
    input logic            res_ok,
    input logic            res_forced,
    input trq_pkg::run_t   res_run,
    input trq_pkg::run_t   res_worst
);

    logic bad_zone;
    assign bad_zone = (32'(res_zone) >= trq_pkg::ZONES);

    // hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_zone) && $stable(res_temp))
        else $error("result word changed while stalled");

    // drop all state fields for zones out of range
    a_bad_zone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_zone |-> res_temp == '0 && !res_ok && !res_forced
                                  && res_run == '0 && res_worst == '0)
        else $error("out-of-range zone reported state");

    // a good sample clears the run
    a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ok |-> res_run == '0 && !res_forced)
        else $error("good sample left a run or forced fallback");

    // worst run never below current run
    a_worst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_worst >= res_run)
        else $error("worst run below current run");

    // fallback only after at least one bad sample
    a_forced_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_forced |-> res_run != '0)
        else $error("fallback forced without a bad run");

endmodule

bind temperature_reading_qualifier trq_checker u_trq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_zone   (result.out_zone),
    .res_temp   (result.zone_temperature_out),
    .res_ok     (result.sample_ok),
    .res_forced (result.fallback_active),
    .res_run    (result.error_run),
    .res_worst  (result.worst_error_run)
);

// File: test/temperature_reading_qualifier_tb.sv
// ----------------------------------------------------------------------------
// temperature_reading_qualifier_tb: self-checking bench for the zone qualifier
// Drives sample words and register writes over the valid/ready channels. It
// keeps its own copy of the per-zone run counters and temperatures, forecasts
// every result word and compares the result stream field by field. Random
// back-pressure is applied on both sides.
// ----------------------------------------------------------------------------
module temperature_reading_qualifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 9;
    localparam int CYCLE_LIMIT = 200000;
    // two pipeline stages; leave plenty of slack for stray words
    localparam int TAIL_CYCLES = 16;

    // calibration per zone: gain in units of 2^-12, offset in 1/16 degC
    localparam int ZONE_GAIN   [8] = '{4055, 4076, 4383, 4014, 4035, 3994, 4076, 4096};
    localparam int ZONE_OFFSET [8] = '{99, 35, -29, 104, 61, 29, 56, 0};

    // one result word as the bench expects it
    typedef struct {
        trq_pkg::zone_t zone;
        trq_pkg::temp_t temperature;
        logic           in_limits;
        logic           forced;
        trq_pkg::run_t  run;
        trq_pkg::run_t  worst_run;
    } zone_report_t;

    typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    // one row of the directed table: a sample word or a register write
    typedef struct {
        row_kind_t          kind;
        trq_pkg::zone_t     zone;
        trq_pkg::temp_t     raw;
        trq_pkg::cfg_idx_t  index;
        trq_pkg::cfg_data_t value;
        bit                 typed;
        zone_report_t       want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    trq_sample_if sample_ch ();
    trq_result_if result_ch ();
    trq_cfg_if    cfg_ch ();

    temperature_reading_qualifier DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the registers, as last written
    trq_pkg::temp_t lo_lim;
    trq_pkg::temp_t hi_lim;
    trq_pkg::run_t  err_lim;
    trq_pkg::temp_t fallback_temp;

    // shadow of the per-zone state
    trq_pkg::run_t  bad_run   [trq_pkg::ZONES];
    trq_pkg::run_t  worst_run [trq_pkg::ZONES];
    trq_pkg::temp_t zone_temp [trq_pkg::ZONES];

    // result words forecast but not yet seen, oldest first
    zone_report_t pending_reports [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int reports_checked;
    int fallbacks_seen;
    int readings_sent;
    int settings_loaded;
    int cycle_count;

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Watchdog: stop a hung run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Scale by the zone gain, round half up, add the offset, clamp to 12 bits.
    function automatic trq_pkg::temp_t calibrate_reading(trq_pkg::zone_t zone,
                                                         trq_pkg::temp_t raw);
        longint scaled;
        scaled = (longint'(ZONE_GAIN[zone]) * longint'(raw) + 2048) >>> 12;
        scaled = scaled + ZONE_OFFSET[zone];
        if (scaled < -2048)
            scaled = -2048;
        if (scaled > 2047)
            scaled = 2047;
        return trq_pkg::temp_t'(scaled);
    endfunction

    // Advance the zone state by one sample word and return the result word.
    function automatic zone_report_t qualify_reading(trq_pkg::zone_t zone,
                                                     trq_pkg::temp_t raw);
        zone_report_t r;
        r.zone        = zone;
        r.temperature = '0;
        r.in_limits   = 1'b0;
        r.forced      = 1'b0;
        r.run         = '0;
        r.worst_run   = '0;
        // zones past the last one leave the state alone and report zeros
        if (int'(zone) >= trq_pkg::ZONES)
            return r;

        r.in_limits = (raw >= lo_lim) && (raw <= hi_lim);
        if (r.in_limits)
        begin
            zone_temp[zone] = calibrate_reading(zone, raw);
            bad_run[zone]   = '0;
        end
        else
        begin
            // hold the run at its ceiling instead of wrapping
            if (bad_run[zone] != trq_pkg::RUN_MAX)
                bad_run[zone] = bad_run[zone] + 1'b1;
            if (worst_run[zone] < bad_run[zone])
                worst_run[zone] = bad_run[zone];
            if (bad_run[zone] > err_lim)
            begin
                zone_temp[zone] = fallback_temp;
                r.forced        = 1'b1;
            end
        end
        r.temperature = zone_temp[zone];
        r.run         = bad_run[zone];
        r.worst_run   = worst_run[zone];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(trq_pkg::zone_t zone, string field, logic [11:0] got,
                               logic [11:0] want_bits);
        if (got !== want_bits)
            flag_mismatch($sformatf("zone %0d %s: got 'h%0h, expected 'h%0h",
                                    zone, field, got, want_bits));
    endtask

    // Sample the result channel at the edge; values are the ones the
    // handshake saw, before any update scheduled at this edge lands.
    always @(posedge clk)
    begin : check_results
        zone_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                flag_mismatch($sformatf("result word for zone %0d with nothing pending",
                                        result_ch.out_zone));
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (want.forced)
                    fallbacks_seen++;
                check_field(want.zone, "out_zone", 12'(result_ch.out_zone),
                            12'(want.zone));
                check_field(want.zone, "zone_temperature_out",
                            12'(result_ch.zone_temperature_out), 12'(want.temperature));
                check_field(want.zone, "sample_ok", 12'(result_ch.sample_ok),
                            12'(want.in_limits));
                check_field(want.zone, "fallback_active", 12'(result_ch.fallback_active),
                            12'(want.forced));
                check_field(want.zone, "error_run", 12'(result_ch.error_run),
                            12'(want.run));
                check_field(want.zone, "worst_error_run", 12'(result_ch.worst_error_run),
                            12'(want.worst_run));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drop ready at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one sample word; forecast its result once it is taken. Valid is
    // left high on return so back-to-back words need no second assignment.
    task automatic send_reading(trq_pkg::zone_t zone, trq_pkg::temp_t raw, bit typed,
                                zone_report_t want);
        int           gap;
        zone_report_t forecast;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.zone_index      <= zone;
        sample_ch.raw_temperature <= raw;
        do @(posedge clk); while (!sample_ch.ready);
        forecast = qualify_reading(zone, raw);
        // a typed-in row overrides the forecast, the state still advances
        pending_reports.push_back(typed ? want : forecast);
        readings_sent++;
    endtask

    // Drop valid and hold until every forecast result word has come back.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
    endtask

    // Write one register; valid stays high for a following write.
    task automatic write_register(trq_pkg::cfg_idx_t index, trq_pkg::cfg_data_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (index)
            trq_pkg::REG_LOW_LIMIT:  lo_lim        = trq_pkg::temp_t'(value);
            trq_pkg::REG_HIGH_LIMIT: hi_lim        = trq_pkg::temp_t'(value);
            trq_pkg::REG_ERR_LIMIT:  err_lim       = value[trq_pkg::RUN_W-1:0];
            trq_pkg::REG_FALLBACK:   fallback_temp = trq_pkg::temp_t'(value);
            default: ;
        endcase
    endtask

    task automatic release_registers();
        cfg_ch.valid <= 1'b0;
    endtask

    // Idle the block, then rewrite all four registers.
    task automatic load_limits(int lo, int hi, int err, int fb);
        wait_for_drain();
        write_register(trq_pkg::REG_LOW_LIMIT, trq_pkg::cfg_data_t'(lo));
        write_register(trq_pkg::REG_HIGH_LIMIT, trq_pkg::cfg_data_t'(hi));
        write_register(trq_pkg::REG_ERR_LIMIT, trq_pkg::cfg_data_t'(err));
        write_register(trq_pkg::REG_FALLBACK, trq_pkg::cfg_data_t'(fb));
        release_registers();
        settings_loaded++;
    endtask

    // Pick a legal window; mostly tight error limits so fallback shows up.
    task automatic load_random_limits();
        int lo;
        int hi;
        int err;
        lo = -880 + int'($urandom_range(0, 1880));
        hi = lo + int'($urandom_range(0, 2000 - lo));
        case ($urandom_range(0, 3))
            0:       err = 0;
            1, 2:    err = int'($urandom_range(1, 12));
            default: err = int'($urandom_range(0, 255));
        endcase
        load_limits(lo, hi, err, -880 + int'($urandom_range(0, 2880)));
    endtask

    // A reading inside the window, hitting its edges now and then.
    function automatic trq_pkg::temp_t pick_in_limits();
        int lo;
        int hi;
        lo = int'(lo_lim);
        hi = int'(hi_lim);
        if (lo > hi)
            return trq_pkg::temp_t'($urandom);
        case ($urandom_range(0, 7))
            0:       return trq_pkg::temp_t'(lo);
            1:       return trq_pkg::temp_t'(hi);
            default: return trq_pkg::temp_t'(lo + int'($urandom_range(0, hi - lo)));
        endcase
    endfunction

    // A reading outside the window, just past an edge now and then.
    function automatic trq_pkg::temp_t pick_out_of_limits();
        int lo;
        int hi;
        lo = int'(lo_lim);
        hi = int'(hi_lim);
        if (lo > hi)
            return trq_pkg::temp_t'($urandom);
        if (hi < 2047 && (lo == -2048 || $urandom_range(0, 1) == 1))
        begin
            if ($urandom_range(0, 3) == 0)
                return trq_pkg::temp_t'(hi + 1);
            return trq_pkg::temp_t'(hi + 1 + int'($urandom_range(0, 2046 - hi)));
        end
        if ($urandom_range(0, 3) == 0)
            return trq_pkg::temp_t'(lo - 1);
        return trq_pkg::temp_t'(lo - 1 - int'($urandom_range(0, lo + 2047)));
    endfunction

    // Random traffic in bursts: each burst sticks to one zone and is either
    // good readings, a longer run of bad ones that can trip the error limit,
    // or raw noise over the whole field.
    task automatic random_phase(int count);
        int             left;
        int             burst;
        int             mode;
        trq_pkg::zone_t zone;
        trq_pkg::temp_t raw;
        zone_report_t   none;
        left  = count;
        burst = 0;
        mode  = 0;
        zone  = '0;
        while (left > 0)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    zone = trq_pkg::zone_t'(7);
                else
                    zone = trq_pkg::zone_t'($urandom_range(0, trq_pkg::ZONES - 1));
                mode  = $urandom_range(0, 9);
                burst = (mode >= 5 && mode <= 7) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 6);
            end
            if (mode <= 4)
                raw = pick_in_limits();
            else if (mode <= 7)
                raw = pick_out_of_limits();
            else
                raw = trq_pkg::temp_t'($urandom);
            // now and then let the pipeline empty completely
            if ($urandom_range(0, 79) == 0)
                wait_for_drain();
            send_reading(zone, raw, 1'b0, none);
            burst--;
            left--;
        end
    endtask

    // Feed one zone a long string of bad readings.
    task automatic hammer_zone(trq_pkg::zone_t zone, int count);
        zone_report_t none;
        repeat (count) send_reading(zone, pick_out_of_limits(), 1'b0, none);
    endtask

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic stim_row_t sample_row(int zone, int raw);
        stim_row_t r;
        r.kind  = ROW_SAMPLE;
        r.zone  = trq_pkg::zone_t'(zone);
        r.raw   = trq_pkg::temp_t'(raw);
        r.index = '0;
        r.value = '0;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(int zone, int raw, int temperature, bit ok,
                                            bit forced, int run, int worst);
        stim_row_t r;
        r                  = sample_row(zone, raw);
        r.typed            = 1'b1;
        r.want.zone        = trq_pkg::zone_t'(zone);
        r.want.temperature = trq_pkg::temp_t'(temperature);
        r.want.in_limits   = ok;
        r.want.forced      = forced;
        r.want.run         = trq_pkg::run_t'(run);
        r.want.worst_run   = trq_pkg::run_t'(worst);
        return r;
    endfunction

    function automatic stim_row_t write_row(trq_pkg::cfg_idx_t index, int value);
        stim_row_t r;
        r       = sample_row(0, 0);
        r.kind  = ROW_WRITE;
        r.index = index;
        r.value = trq_pkg::cfg_data_t'(value);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t      rows [$];
        bit             after_write;
        int             directed_words;
        trq_pkg::zone_t hot_zone;

        // known values on every input before the first edge
        rst_n                     = 1'b0;
        sample_ch.valid           = 1'b0;
        sample_ch.zone_index      = '0;
        sample_ch.raw_temperature = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;
        result_ch.ready           = 1'b0;

        // shadow state starts where reset leaves the block
        lo_lim        = trq_pkg::LOW_LIMIT_RST;
        hi_lim        = trq_pkg::HIGH_LIMIT_RST;
        err_lim       = trq_pkg::ERR_LIMIT_RST;
        fallback_temp = trq_pkg::FALLBACK_RST;
        for (int z = 0; z < trq_pkg::ZONES; z++)
        begin
            bad_run[z]   = '0;
            worst_run[z] = '0;
            zone_temp[z] = '0;
        end

        // first stage: slow receiver, occasionally idle sender
        send_idle_pct = 31;
        recv_idle_pct = 75;

        // Directed table. Typed rows are ones whose result is obvious from
        // reset values, the limits or the fallback; the rest go through the
        // predictor. Start at reset limits 80..1600, error limit 50.
        rows.push_back(sample_row(0, 80));                         // low edge, good
        rows.push_back(sample_row(6, 1600));                       // high edge, good
        rows.push_back(typed_row(1, 79, 0, 0, 0, 1, 1));           // just below
        rows.push_back(typed_row(1, 1601, 0, 0, 0, 2, 2));         // just above
        rows.push_back(typed_row(1, -2048, 0, 0, 0, 3, 3));        // field minimum
        rows.push_back(typed_row(1, 2047, 0, 0, 0, 4, 4));         // field maximum
        rows.push_back(typed_row(1, 0, 0, 0, 0, 5, 5));
        rows.push_back(typed_row(1, -1, 0, 0, 0, 6, 6));
        rows.push_back(typed_row(7, 2047, 0, 0, 0, 0, 0));         // zone past the end
        rows.push_back(typed_row(7, -2048, 0, 0, 0, 0, 0));
        rows.push_back(sample_row(1, 800));                        // clears the run
        // error limit 0: the first bad reading forces the fallback
        rows.push_back(write_row(trq_pkg::REG_ERR_LIMIT, 0));
        rows.push_back(write_row(trq_pkg::REG_FALLBACK, -880));
        rows.push_back(typed_row(3, 2047, -880, 0, 1, 1, 1));
        rows.push_back(typed_row(3, -2048, -880, 0, 1, 2, 2));
        // widest window: zone 2 gain pushes the top reading into the clamp
        rows.push_back(write_row(trq_pkg::REG_LOW_LIMIT, -880));
        rows.push_back(write_row(trq_pkg::REG_HIGH_LIMIT, 2000));
        rows.push_back(sample_row(2, 2000));
        rows.push_back(sample_row(2, -880));
        rows.push_back(sample_row(4, 0));
        rows.push_back(sample_row(5, -1));
        rows.push_back(sample_row(3, 1000));
        // inverted window: nothing passes
        rows.push_back(write_row(trq_pkg::REG_LOW_LIMIT, 2000));
        rows.push_back(write_row(trq_pkg::REG_HIGH_LIMIT, -880));
        rows.push_back(typed_row(0, 500, -880, 0, 1, 1, 1));
        rows.push_back(typed_row(6, 2000, -880, 0, 1, 1, 1));
        // error limit 255: the run can never exceed it, last value holds
        rows.push_back(write_row(trq_pkg::REG_ERR_LIMIT, 255));
        rows.push_back(write_row(trq_pkg::REG_FALLBACK, 2000));
        rows.push_back(typed_row(6, -880, -880, 0, 0, 2, 2));
        rows.push_back(sample_row(3, 2047));

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        // walk the table; empty the pipeline before a write, release the
        // write channel before the next sample word
        after_write = 1'b0;
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                if (!after_write)
                    wait_for_drain();
                write_register(rows[i].index, rows[i].value);
                after_write = 1'b1;
            end
            else
            begin
                if (after_write)
                    release_registers();
                after_write = 1'b0;
                send_reading(rows[i].zone, rows[i].raw, rows[i].typed, rows[i].want);
            end
        end
        directed_words = readings_sent;

        // random traffic, first at reset values, then random windows
        load_limits(80, 1600, 50, 160);
        random_phase(90);
        load_random_limits();
        random_phase(90);

        // second stage: idle sender, fast receiver
        send_idle_pct = 75;
        recv_idle_pct = 31;
        load_random_limits();
        random_phase(90);
        load_random_limits();
        random_phase(90);
        load_limits(1200, -200, 3, -880 + int'($urandom_range(0, 2880)));
        random_phase(40);

        // last stage: full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // saturate one zone's run at 255 with the fallback out of reach,
        // then drop the limit to 254 so the saturated run trips it
        hot_zone = trq_pkg::zone_t'($urandom_range(0, trq_pkg::ZONES - 1));
        load_limits(-880, 2000, 255, 2000);
        hammer_zone(hot_zone, 262);
        load_limits(-880, 2000, 254, -880);
        hammer_zone(hot_zone, 5);
        random_phase(60);
        load_random_limits();
        random_phase(90);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d sample words (%0d directed) under %0d register settings",
                 readings_sent, directed_words, settings_loaded);
        $display("checked %0d result words, %0d with fallback forced, %0d mismatches",
                 reports_checked, fallbacks_seen, mismatch_count);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/trq_pkg.sv
src/trq_ifs.sv
src/temperature_reading_qualifier.sv
src/trq_checker.sv
test/temperature_reading_qualifier_tb.sv
